>>> src/assert_macros.svh
// Assertion macros shared by the checking code of the block.
// Each macro samples on clk; the first is masked during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked while out of reset
`define UMC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("umc assertion failed");

// Property checked at every edge, reset included
`define UMC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("umc assertion failed");

`endif

>>> src/umc_pkg.sv
// Package for the 2x2 unitary matrix check: item types, widths, constants.
// No dependencies.
`timescale 1ns / 1ps

package umc_pkg;

  localparam int unsigned ELEM_W  = 16;   // Q2.14 matrix part
  localparam int unsigned P_W     = 20;   // rounded part of M*M^H
  localparam int unsigned E_W     = 21;   // phase part
  localparam int unsigned OP_W    = 22;   // multiplier operand
  localparam int unsigned ACC_W   = 46;   // accumulator
  localparam int unsigned DIV_W   = 64;   // divider remainder
  localparam int unsigned QB_W    = 18;   // raw quotient bits
  localparam int unsigned REG_W   = 15;   // configuration register
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic signed [ELEM_W-1:0] ONE_Q14 = 16'sd16384;
  localparam logic [REG_W-1:0] TOL_RESET = 15'd16;
  localparam logic [REG_W-1:0] NZL_RESET = 15'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NZL = 2'd1;

  typedef struct packed {
    logic signed [ELEM_W-1:0] a_re;
    logic signed [ELEM_W-1:0] a_im;
    logic signed [ELEM_W-1:0] b_re;
    logic signed [ELEM_W-1:0] b_im;
    logic signed [ELEM_W-1:0] c_re;
    logic signed [ELEM_W-1:0] c_im;
    logic signed [ELEM_W-1:0] d_re;
    logic signed [ELEM_W-1:0] d_im;
  } in_t;

  typedef struct packed {
    logic                     accepted;
    logic signed [ELEM_W-1:0] held_a_re;
    logic signed [ELEM_W-1:0] held_a_im;
    logic signed [ELEM_W-1:0] held_b_re;
    logic signed [ELEM_W-1:0] held_b_im;
    logic signed [ELEM_W-1:0] held_c_re;
    logic signed [ELEM_W-1:0] held_c_im;
    logic signed [ELEM_W-1:0] held_d_re;
    logic signed [ELEM_W-1:0] held_d_im;
  } out_t;

  // Handshake between sequencer and divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> src/umc_div.sv
// Restoring divider: round(num * 2^14 / den), ties away from zero, saturated to 16 bits.
// Depends on umc_pkg. Loads on start, then produces one quotient bit per cycle.
`timescale 1ns / 1ps

module umc_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [umc_pkg::ACC_W-1:0]  num,
  input  logic        [umc_pkg::ACC_W-1:0]  den,
  output umc_pkg::div_stat_t                stat,
  output logic signed [umc_pkg::ELEM_W-1:0] quo
);

  localparam logic [umc_pkg::QB_W-1:0] QB_W_LIM_POS = 18'd32767;
  localparam logic [umc_pkg::QB_W-1:0] QB_W_LIM_NEG = 18'd32768;

  logic [umc_pkg::DIV_W-1:0] rem;
  logic [umc_pkg::DIV_W-1:0] dsh;
  logic [umc_pkg::QB_W-1:0]  q;
  logic                      neg;
  logic [4:0]                step;
  logic [umc_pkg::ACC_W-1:0] mag;
  logic                      ge;

  assign mag = num[umc_pkg::ACC_W-1] ? umc_pkg::ACC_W'(-num) : umc_pkg::ACC_W'(num);
  assign ge  = (rem >= dsh);

  // Iteration: compare and subtract the shifted divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      step <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        // N = 2*mag*2^14 + den, divisor 2*den placed at quotient bit 17
        rem       <= (umc_pkg::DIV_W'(mag) << 15) + umc_pkg::DIV_W'(den);
        dsh       <= umc_pkg::DIV_W'(den) << umc_pkg::QB_W;
        q         <= '0;
        neg       <= num[umc_pkg::ACC_W-1];
        step      <= '0;
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        if (ge) rem <= rem - dsh;
        q    <= {q[umc_pkg::QB_W-2:0], ge};
        dsh  <= dsh >> 1;
        step <= step + 5'd1;
        if (step == 5'(umc_pkg::QB_W - 1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  // Saturation to the signed 16 bit range
  always_comb begin
    if (neg) begin
      if (q > QB_W_LIM_NEG) quo = 16'sh8000;
      else                  quo = umc_pkg::ELEM_W'(-$signed({1'b0, q}));
    end else begin
      if (q > QB_W_LIM_POS) quo = 16'sh7FFF;
      else                  quo = umc_pkg::ELEM_W'(q);
    end
  end

endmodule

>>> src/unitary_matrix_check.sv
// Top level of the 2x2 unitary matrix check: sequencer, shared MAC, held matrix.
// Depends on umc_pkg, umc_div and assert_macros.svh.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | in_item  (umc_pkg::in_t)
//   out     | output    | out_valid / out_stall| out_item (umc_pkg::out_t)
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An item takes longer when M*M^H is not already near identity and the
// phase divide runs; the shared 22x22 MAC and the one-bit-per-cycle divider
// set the time per item. in_stall is high from acceptance until the result
// item is taken. Reset (rst, synchronous) restores the control registers,
// the configuration registers and the identity held matrix; no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module unitary_matrix_check (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  umc_pkg::in_t                         in_item,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output umc_pkg::out_t                        out_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [umc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [umc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_P, S_CHK, S_E, S_NUM, S_DIV, S_OUT} state_t;

  state_t state;
  logic [4:0] cnt;
  logic [2:0] qn;
  logic       use_diff;

  logic [umc_pkg::REG_W-1:0] tol, nzl;
  logic signed [umc_pkg::ELEM_W-1:0] m    [8];
  logic signed [umc_pkg::ELEM_W-1:0] held [8];
  logic signed [umc_pkg::P_W-1:0]    p    [8];
  logic signed [umc_pkg::E_W-1:0]    er, ei;
  logic signed [umc_pkg::ACC_W-1:0]  acc, num;
  logic        [umc_pkg::ACC_W-1:0]  den;

  logic signed [umc_pkg::OP_W-1:0]     op_a, op_b;
  logic                                op_sub, op_clr;
  logic signed [2*umc_pkg::OP_W-1:0]   prod;
  logic signed [umc_pkg::ACC_W-1:0]    acc_next;
  logic signed [umc_pkg::ACC_W-1:0]    rnd_sum;

  logic               div_start;
  umc_pkg::div_stat_t div_stat;
  logic signed [umc_pkg::ELEM_W-1:0] quo;

  // indices for the M*M^H products
  logic [2:0] pn;
  logic       pi_, pj, pk, psub;
  assign pn   = cnt[4:2];
  assign pi_  = pn[2];
  assign pj   = pn[1];
  assign pk   = cnt[1];
  assign psub = cnt[0];

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  // Operand selection for the shared MAC
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    op_clr = 1'b0;
    unique case (state)
      S_P: begin
        op_clr = (cnt[1:0] == 2'd0);
        if (!pn[0]) begin
          op_a = psub ? umc_pkg::OP_W'(m[{pi_, pk, 1'b1}]) : umc_pkg::OP_W'(m[{pi_, pk, 1'b0}]);
          op_b = psub ? umc_pkg::OP_W'(m[{pj, pk, 1'b1}])  : umc_pkg::OP_W'(m[{pj, pk, 1'b0}]);
        end else begin
          op_a   = psub ? umc_pkg::OP_W'(m[{pi_, pk, 1'b0}]) : umc_pkg::OP_W'(m[{pi_, pk, 1'b1}]);
          op_b   = psub ? umc_pkg::OP_W'(m[{pj, pk, 1'b1}])  : umc_pkg::OP_W'(m[{pj, pk, 1'b0}]);
          op_sub = psub;
        end
      end
      S_E: begin
        op_clr = (cnt == 5'd1);
        if (cnt == 5'd3) begin
          op_a = $signed({7'd0, nzl});
          op_b = $signed({7'd0, nzl});
        end else if (cnt == 5'd2) begin
          op_a = umc_pkg::OP_W'(ei);
          op_b = umc_pkg::OP_W'(ei);
        end else begin
          op_a = umc_pkg::OP_W'(er);
          op_b = umc_pkg::OP_W'(er);
        end
      end
      S_NUM: begin
        op_clr = (cnt == 5'd0);
        if (!qn[0]) begin
          op_a = (cnt == 5'd0) ? umc_pkg::OP_W'(p[{qn[2:1], 1'b0}])
                               : umc_pkg::OP_W'(p[{qn[2:1], 1'b1}]);
          op_b = (cnt == 5'd0) ? umc_pkg::OP_W'(er) : umc_pkg::OP_W'(ei);
        end else begin
          op_a   = (cnt == 5'd0) ? umc_pkg::OP_W'(p[{qn[2:1], 1'b1}])
                                 : umc_pkg::OP_W'(p[{qn[2:1], 1'b0}]);
          op_b   = (cnt == 5'd0) ? umc_pkg::OP_W'(er) : umc_pkg::OP_W'(ei);
          op_sub = (cnt != 5'd0);
        end
      end
      default: ;
    endcase
  end

  assign prod     = op_a * op_b;
  assign acc_next = (op_clr ? '0 : acc)
                  + (op_sub ? -umc_pkg::ACC_W'(prod) : umc_pkg::ACC_W'(prod));
  assign rnd_sum  = (acc_next + 46'sd8192) >>> 14;

  // Tolerance tests against the identity
  logic signed [umc_pkg::P_W:0]    pd;
  logic [umc_pkg::P_W:0]           pd_abs;
  logic signed [umc_pkg::ELEM_W+1:0] qd;
  logic [umc_pkg::ELEM_W+1:0]        qd_abs;
  logic                              p_ok, q_ok;

  always_comb begin
    pd     = (umc_pkg::P_W+1)'(p[cnt[2:0]])
           - ((cnt[2:0] == 3'd0 || cnt[2:0] == 3'd6) ? 21'sd16384 : 21'sd0);
    pd_abs = pd[umc_pkg::P_W] ? (umc_pkg::P_W+1)'(-pd) : (umc_pkg::P_W+1)'(pd);
    p_ok   = (pd_abs <= (umc_pkg::P_W+1)'(tol));
    qd     = (umc_pkg::ELEM_W+2)'(quo)
           - ((qn == 3'd0 || qn == 3'd6) ? 18'sd16384 : 18'sd0);
    qd_abs = qd[umc_pkg::ELEM_W+1] ? (umc_pkg::ELEM_W+2)'(-qd) : (umc_pkg::ELEM_W+2)'(qd);
    q_ok   = (qd_abs <= (umc_pkg::ELEM_W+2)'(tol));
  end

  umc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .stat  (div_stat),
    .quo   (quo)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= umc_pkg::TOL_RESET;
      nzl <= umc_pkg::NZL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == umc_pkg::CFG_TOL) tol <= cfg_data[umc_pkg::REG_W-1:0];
      if (cfg_index == umc_pkg::CFG_NZL) nzl <= cfg_data[umc_pkg::REG_W-1:0];
    end
  end

  // Sequencer, datapath registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      qn        <= '0;
      use_diff  <= 1'b0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      for (int k = 0; k < 8; k++) held[k] <= '0;
      held[0]   <= umc_pkg::ONE_Q14;
      held[6]   <= umc_pkg::ONE_Q14;
    end else begin
      div_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            m[0] <= in_item.a_re; m[1] <= in_item.a_im;
            m[2] <= in_item.b_re; m[3] <= in_item.b_im;
            m[4] <= in_item.c_re; m[5] <= in_item.c_im;
            m[6] <= in_item.d_re; m[7] <= in_item.d_im;
            cnt      <= '0;
            use_diff <= 1'b0;
            state    <= S_P;
          end
        end
        // four MAC steps per part of P
        S_P: begin
          acc <= acc_next;
          if (cnt[1:0] == 2'd3) p[pn] <= umc_pkg::P_W'(rnd_sum);
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            cnt   <= '0;
            state <= S_CHK;
          end
        end
        // first identity test, one part a cycle
        S_CHK: begin
          if (!p_ok) begin
            cnt   <= '0;
            state <= S_E;
          end else if (cnt[2:0] == 3'd7) begin
            state     <= S_OUT;
            out_valid <= 1'b1;
            out_item  <= {1'b1, m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7]};
            for (int k = 0; k < 8; k++) held[k] <= m[k];
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        // phase and its squared magnitude
        S_E: begin
          unique case (cnt)
            5'd0: begin
              er  <= umc_pkg::E_W'(p[0]) + umc_pkg::E_W'(p[2]);
              ei  <= umc_pkg::E_W'(p[1]) + umc_pkg::E_W'(p[3]);
              cnt <= 5'd1;
            end
            5'd1, 5'd2: begin
              acc <= acc_next;
              cnt <= cnt + 5'd1;
            end
            default: begin
              if (!use_diff && (acc < umc_pkg::ACC_W'(prod))) begin
                use_diff <= 1'b1;
                er  <= umc_pkg::E_W'(p[0]) - umc_pkg::E_W'(p[2]);
                ei  <= umc_pkg::E_W'(p[1]) - umc_pkg::E_W'(p[3]);
                cnt <= 5'd1;
              end else if (acc == '0) begin
                state     <= S_OUT;
                out_valid <= 1'b1;
                out_item  <= {1'b0, held[0], held[1], held[2], held[3],
                              held[4], held[5], held[6], held[7]};
              end else begin
                den   <= umc_pkg::ACC_W'(acc);
                qn    <= '0;
                cnt   <= '0;
                state <= S_NUM;
              end
            end
          endcase
        end
        // numerator of one quotient part
        S_NUM: begin
          acc <= acc_next;
          if (cnt == 5'd0) begin
            cnt <= 5'd1;
          end else begin
            num       <= acc_next;
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end
        // wait for the divider, then test the part
        S_DIV: begin
          if (div_stat.done) begin
            if (!q_ok) begin
              state     <= S_OUT;
              out_valid <= 1'b1;
              out_item  <= {1'b0, held[0], held[1], held[2], held[3],
                            held[4], held[5], held[6], held[7]};
            end else if (qn == 3'd7) begin
              state     <= S_OUT;
              out_valid <= 1'b1;
              out_item  <= {1'b1, m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7]};
              for (int k = 0; k < 8; k++) held[k] <= m[k];
            end else begin
              qn    <= qn + 3'd1;
              cnt   <= '0;
              state <= S_NUM;
            end
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  `UMC_ASSERT(a_no_accept_while_result, (in_valid && !in_stall) |-> !out_valid)
  `UMC_ASSERT(a_held_only_on_accept, !$stable(held[0]) |-> (out_valid && out_item.accepted))
  `UMC_ASSERT(a_div_start_idle, div_start |-> (!div_stat.busy && state == S_DIV))

endmodule
